### rtl/dsort_pkg.sv
// ----------------------------------------------------------------------------
// dsort_pkg: shared types and constants for the date sorter
// Word formats, sort key, controller state, and the command/status bundles
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package dsort_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int KEY_W        = 23;

    typedef logic [KEY_W-1:0] key_t;   // {year, month, day}

    typedef struct packed {
        logic [4:0]  day;
        logic [3:0]  month;
        logic [13:0] year;
        logic        last_item;
    } date_in_t;

    typedef struct packed {
        logic [4:0]  out_day;
        logic [3:0]  out_month;
        logic [13:0] out_year;
        logic        run_end;
        logic        overflow;
    } date_out_t;

    typedef enum logic {
        ST_LOAD  = 1'b0,
        ST_DRAIN = 1'b1
    } state_t;

    typedef struct packed {
        logic insert;   // place the input date into the sorted chain
        logic pop;      // emit the head of the chain and shift down
    } cmd_t;

    typedef struct packed {
        logic last_one; // exactly one date left in the chain
    } stat_t;

endpackage

### rtl/dsort_ctrl.sv
// ----------------------------------------------------------------------------
// dsort_ctrl: sequencing for the date sorter
// Loads dates while idle, then drains the sorted chain after the last one.
// ----------------------------------------------------------------------------
module dsort_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              last_item,
    input  dsort_pkg::stat_t  stat,
    output dsort_pkg::cmd_t   cmd,
    output logic              busy
);

    dsort_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dsort_pkg::ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b0;
        case (state_reg)
            dsort_pkg::ST_LOAD:
            begin
                cmd.insert = start;
                if (start && last_item)
                begin
                    state_next = dsort_pkg::ST_DRAIN;
                end
            end
            dsort_pkg::ST_DRAIN:
            begin
                busy    = 1'b1;
                cmd.pop = 1'b1;
                if (stat.last_one)
                begin
                    state_next = dsort_pkg::ST_LOAD;
                end
            end
            default:
            begin
                state_next = dsort_pkg::ST_LOAD;
            end
        endcase
    end

endmodule

### rtl/dsort_dp.sv
// ----------------------------------------------------------------------------
// dsort_dp: insertion chain and output register for the date sorter
// Each cell compares its key with the incoming one; larger keys shift up one
// place so the new date lands after all keys less than or equal to it.
// ----------------------------------------------------------------------------
module dsort_dp #(
    parameter int CAPACITY = dsort_pkg::CAPACITY_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  dsort_pkg::cmd_t      cmd,
    input  dsort_pkg::date_in_t  item,
    output dsort_pkg::stat_t     stat,
    output dsort_pkg::date_out_t result,
    output logic                 strobe
);

    localparam int CW = $clog2(CAPACITY + 1);

    dsort_pkg::key_t      entry_reg  [CAPACITY];
    dsort_pkg::key_t      entry_next [CAPACITY];
    logic [CAPACITY-1:0]  gt;
    logic [CW-1:0]        count_reg, count_next;
    logic                 dropped_reg, dropped_next;
    dsort_pkg::date_out_t result_reg, result_next;
    logic                 strobe_reg;
    dsort_pkg::key_t      key;
    logic                 full;
    logic                 do_ins;

    assign key    = {item.year, item.month, item.day};
    assign full   = (count_reg == CW'(CAPACITY));
    assign do_ins = cmd.insert && !full;

    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++)
        begin : g_cell
            logic take;
            assign gt[i] = (CW'(i) < count_reg) && (entry_reg[i] > key);
            assign take  = gt[i] || (CW'(i) == count_reg);

            always_comb
            begin
                entry_next[i] = entry_reg[i];
                if (cmd.pop)
                begin
                    if (i < CAPACITY - 1)
                    begin
                        entry_next[i] = entry_reg[(i + 1) % CAPACITY];
                    end
                end
                else if (do_ins && take)
                begin
                    if (i > 0 && gt[(i + CAPACITY - 1) % CAPACITY])
                    begin
                        entry_next[i] = entry_reg[(i + CAPACITY - 1) % CAPACITY];
                    end
                    else
                    begin
                        entry_next[i] = key;
                    end
                end
            end

            always_ff @(posedge clk)
            begin
                entry_reg[i] <= entry_next[i];
            end
        end
    endgenerate

    always_comb
    begin
        count_next   = count_reg;
        dropped_next = dropped_reg;
        result_next  = result_reg;
        if (cmd.pop)
        begin
            count_next            = count_reg - CW'(1);
            result_next.out_day   = entry_reg[0][4:0];
            result_next.out_month = entry_reg[0][8:5];
            result_next.out_year  = entry_reg[0][22:9];
            result_next.run_end   = (count_reg == CW'(1));
            result_next.overflow  = dropped_reg;
            if (count_reg == CW'(1))
            begin
                dropped_next = 1'b0;
            end
        end
        else if (cmd.insert)
        begin
            if (full)
            begin
                dropped_next = 1'b1;
            end
            else
            begin
                count_next = count_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            dropped_reg <= 1'b0;
            strobe_reg  <= 1'b0;
        end
        else
        begin
            count_reg   <= count_next;
            dropped_reg <= dropped_next;
            strobe_reg  <= cmd.pop;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign stat.last_one = (count_reg == CW'(1));
    assign result        = result_reg;
    assign strobe        = strobe_reg;

endmodule

### rtl/date_sorter_top.sv
// ----------------------------------------------------------------------------
// date_sorter_top: chronological sorter for a set of calendar dates
// Collects up to CAPACITY dates and emits them oldest first on the last one.
//
//   channel  | ports               | handshake
//   ---------+---------------------+------------------------------------------
//   input    | item (date_in_t)    | word taken at edge with start & !busy
//   output   | result (date_out_t) | word valid for one cycle while strobe=1
//
// The insertion chain places each date as it is taken, by a parallel compare
// in every cell. After the last date the chain drains one word per cycle: a
// set of n stored dates gives n results, busy high starting the cycle after
// the last date is taken and until the last stored date is popped. The
// final result shows in the first cycle with busy low, from the output
// register, while a new date can already be taken. Reset clears the fill
// count, the overflow mark, the strobe and the controller; the stored keys
// need no reset. The receiver cannot stall the output.
// ----------------------------------------------------------------------------
module date_sorter_top #(
    parameter int CAPACITY = dsort_pkg::CAPACITY_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  dsort_pkg::date_in_t  item,
    output dsort_pkg::date_out_t result,
    output logic                 strobe
);

    dsort_pkg::cmd_t  cmd;
    dsort_pkg::stat_t stat;

    // Controller: load phase while idle, drain phase after the last date.
    dsort_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .last_item (item.last_item),
        .stat      (stat),
        .cmd       (cmd),
        .busy      (busy)
    );

    // Datapath: sorted chain of keys plus the registered output word.
    dsort_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .item   (item),
        .stat   (stat),
        .result (result),
        .strobe (strobe)
    );

endmodule
